// File: hw/rtl/skwp_pkg.sv
package skwp_pkg;

    localparam int TableDepthDefault = 1024;

    localparam int ModeW   = 2;
    localparam int KeyW    = 64;
    localparam int MoveW   = 16;
    localparam int WeightW = 16;
    localparam int RandW   = 32;
    localparam int StatusW = 2;

    // item modes
    localparam logic [ModeW-1:0] ModeAppend = 2'd0;
    localparam logic [ModeW-1:0] ModeProbe  = 2'd1;
    localparam logic [ModeW-1:0] ModeClear  = 2'd2;

    // result status codes
    localparam logic [StatusW-1:0] StatDone  = 2'd0;
    localparam logic [StatusW-1:0] StatFound = 2'd1;
    localparam logic [StatusW-1:0] StatMiss  = 2'd2;
    localparam logic [StatusW-1:0] StatFull  = 2'd3;

    // one table row
    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [MoveW-1:0]   move;
        logic [WeightW-1:0] weight;
    } t_entry;

endpackage

// File: hw/rtl/skwp_mod.sv
module skwp_mod #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CntW = $clog2(DVD_W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic [DVS_W-1:0] w_next;

    // restoring remainder, one dividend bit a cycle
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_next  = (w_trial >= {1'b0, r_dvs}) ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DVD_W);
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_next;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/sorted_key_table_weighted_pick.sv
// sorted key table with weighted pick. start is taken when busy is low; every item
// gives exactly one result word, shown on o_status/o_move for a single cycle with
// o_valid high, and the receiver cannot stall it. append, clear and the unused mode
// are handled at once: the result shows the cycle after start and busy never rises,
// so these items may be issued every cycle. a probe holds busy while it works on the
// table memory, which gives one registered read per cycle: a binary search, a walk
// back to the first match, a forward scan of the run, and in weighted mode with a
// nonzero total weight a remainder unit plus a final pass that walks the run.
// the user must append entries in ascending key order; the block itself does not
// enforce it. the memory needs no clearing after reset since only entries below
// the fill count are read.
module sorted_key_table_weighted_pick #(
    parameter int TABLE_DEPTH = skwp_pkg::TableDepthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [skwp_pkg::ModeW-1:0]    i_mode,
    input  logic [skwp_pkg::KeyW-1:0]     i_key,
    input  logic [skwp_pkg::MoveW-1:0]    i_entry_move,
    input  logic [skwp_pkg::WeightW-1:0]  i_entry_weight,
    input  logic                          i_pick_best,
    input  logic [skwp_pkg::RandW-1:0]    i_random_value,
    output logic                          o_valid,
    output logic [skwp_pkg::StatusW-1:0]  o_status,
    output logic [skwp_pkg::MoveW-1:0]    o_move
);

    import skwp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = CW + WeightW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SCMP,
        ST_BACK,
        ST_BCMP,
        ST_FRD,
        ST_FCMP,
        ST_PICK,
        ST_MOD,
        ST_WRD,
        ST_WCMP
    } t_state;

    t_state r_state;

    // table memory
    t_entry r_table [TABLE_DEPTH];
    t_entry r_rdata;
    logic   w_we;
    logic [AW-1:0] w_raddr;

    // fill count and probe context
    logic [CW-1:0]      r_count;
    logic [KeyW-1:0]    r_want;
    logic               r_best;
    logic [RandW-1:0]   r_rnd;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hiex;
    logic [CW-1:0]      r_first;
    logic [CW-1:0]      r_idx;
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_rem;
    logic [WeightW-1:0] r_bweight;
    logic [MoveW-1:0]   r_bmove;
    logic [MoveW-1:0]   r_fmove;

    logic                r_valid;
    logic [StatusW-1:0]  r_status;
    logic [MoveW-1:0]    r_move;

    // binary search midpoint, same rounding as lo + (hi - lo) / 2 with inclusive hi
    logic [CW-1:0] w_span;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_prev;

    logic          w_mod_start;
    logic          w_mod_done;
    logic [TW-1:0] w_mod_rem;
    logic [TW-1:0] w_wext;

    assign w_span = r_hiex - r_lo - CW'(1);
    assign w_mid  = r_lo + (w_span >> 1);
    assign w_prev = r_first - CW'(1);
    assign w_wext = TW'(r_rdata.weight);

    assign w_we = (r_state == ST_IDLE) && start && (i_mode == ModeAppend)
                  && (r_count < CW'(TABLE_DEPTH));

    always_comb begin
        case (r_state)
            ST_SRCH: w_raddr = w_mid[AW-1:0];
            ST_BACK: w_raddr = w_prev[AW-1:0];
            default: w_raddr = r_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[r_count[AW-1:0]] <= '{key: i_key, move: i_entry_move,
                                          weight: i_entry_weight};
        end
        r_rdata <= r_table[w_raddr];
    end

    assign w_mod_start = (r_state == ST_PICK) && !r_best && (r_total != '0);

    skwp_mod #(
        .DVD_W (RandW),
        .DVS_W (TW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_total),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_status <= StatDone;
            r_move   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_move <= '0;
                        case (i_mode)
                            ModeAppend: begin
                                r_valid <= 1'b1;
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_count  <= r_count + CW'(1);
                                    r_status <= StatDone;
                                end else begin
                                    r_status <= StatFull;
                                end
                            end
                            ModeProbe: begin
                                r_want  <= i_key;
                                r_best  <= i_pick_best;
                                r_rnd   <= i_random_value;
                                r_lo    <= '0;
                                r_hiex  <= r_count;
                                r_state <= ST_SRCH;
                            end
                            ModeClear: begin
                                r_count  <= '0;
                                r_valid  <= 1'b1;
                                r_status <= StatDone;
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= StatDone;
                            end
                        endcase
                    end
                end
                ST_SRCH: begin
                    if (r_lo >= r_hiex) begin
                        r_valid  <= 1'b1;
                        r_status <= StatMiss;
                        r_move   <= '0;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_idx   <= w_mid;
                        r_state <= ST_SCMP;
                    end
                end
                ST_SCMP: begin
                    if (r_rdata.key == r_want) begin
                        r_first <= r_idx;
                        r_state <= ST_BACK;
                    end else if (r_rdata.key < r_want) begin
                        r_lo    <= r_idx + CW'(1);
                        r_state <= ST_SRCH;
                    end else begin
                        r_hiex  <= r_idx;
                        r_state <= ST_SRCH;
                    end
                end
                // walk back to the first matching entry
                ST_BACK: begin
                    if (r_first == '0) begin
                        r_idx   <= r_first;
                        r_total <= '0;
                        r_state <= ST_FRD;
                    end else begin
                        r_state <= ST_BCMP;
                    end
                end
                ST_BCMP: begin
                    if (r_rdata.key == r_want) begin
                        r_first <= w_prev;
                        r_state <= ST_BACK;
                    end else begin
                        r_idx   <= r_first;
                        r_total <= '0;
                        r_state <= ST_FRD;
                    end
                end
                // forward scan of the run: heaviest move, first move, total weight
                ST_FRD: begin
                    if (r_idx < r_count) begin
                        r_state <= ST_FCMP;
                    end else begin
                        r_state <= ST_PICK;
                    end
                end
                ST_FCMP: begin
                    if (r_rdata.key == r_want) begin
                        if (r_idx == r_first) begin
                            r_fmove   <= r_rdata.move;
                            r_bmove   <= r_rdata.move;
                            r_bweight <= r_rdata.weight;
                        end else if (r_rdata.weight > r_bweight) begin
                            r_bmove   <= r_rdata.move;
                            r_bweight <= r_rdata.weight;
                        end
                        r_total <= r_total + w_wext;
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_FRD;
                    end else begin
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (r_best) begin
                        r_valid  <= 1'b1;
                        r_status <= StatFound;
                        r_move   <= r_bmove;
                        r_state  <= ST_IDLE;
                    end else if (r_total == '0) begin
                        r_valid  <= 1'b1;
                        r_status <= StatFound;
                        r_move   <= r_fmove;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (w_mod_done) begin
                        r_rem   <= w_mod_rem;
                        r_idx   <= r_first;
                        r_state <= ST_WRD;
                    end
                end
                // cumulative walk, the remainder is below the total so it ends in the run
                ST_WRD: begin
                    r_state <= ST_WCMP;
                end
                ST_WCMP: begin
                    if (r_rem < w_wext) begin
                        r_valid  <= 1'b1;
                        r_status <= StatFound;
                        r_move   <= r_rdata.move;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_rem   <= r_rem - w_wext;
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_WRD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_move   = r_move;

    // fill count never runs past the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // the remainder walk only reads filled entries
    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WCMP) |-> (r_idx < r_count))
        else $error("weighted walk ran past the filled entries");

    // remainder unit reports only while a probe waits on it
    a_mod_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == ST_MOD))
        else $error("remainder done outside of weighted pick");

    // move is zero unless a move was found
    a_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != StatFound)) |-> (o_move == '0))
        else $error("nonzero move without a found status");

endmodule

// File: verif/tb_sorted_key_table_weighted_pick.sv
`timescale 1ns / 100ps

class pick_scoreboard;
    typedef struct packed {
        logic [skwp_pkg::StatusW-1:0] status;
        logic [skwp_pkg::MoveW-1:0]   move;
    } t_reply;

    logic [skwp_pkg::KeyW-1:0]    key_tbl    [skwp_pkg::TableDepthDefault];
    logic [skwp_pkg::MoveW-1:0]   move_tbl   [skwp_pkg::TableDepthDefault];
    logic [skwp_pkg::WeightW-1:0] weight_tbl [skwp_pkg::TableDepthDefault];
    int unsigned fill_count;
    t_reply      reply_q[$];
    int unsigned mismatch_count;

    function new();
        fill_count     = 0;
        mismatch_count = 0;
    endfunction

    function void flag(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", what);
    endfunction

    // binary search, back up to the first match, then choose within the run
    function t_reply probe_reply(logic [skwp_pkg::KeyW-1:0] want, bit best,
                                 logic [skwp_pkg::RandW-1:0] draw);
        t_reply      r;
        int          lo, hi, mid, hit, first, last, pick;
        logic [31:0] total, rem;
        r.status = skwp_pkg::StatMiss;
        r.move   = '0;
        lo  = 0;
        hi  = int'(fill_count) - 1;
        hit = -1;
        while (lo <= hi && hit < 0) begin
            mid = lo + (hi - lo) / 2;
            if (key_tbl[mid] == want)
                hit = mid;
            else if (key_tbl[mid] < want)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        if (hit < 0)
            return r;
        first = hit;
        while (first > 0 && key_tbl[first-1] == want)
            first--;
        last = first;
        while (last + 1 < int'(fill_count) && key_tbl[last+1] == want)
            last++;
        r.status = skwp_pkg::StatFound;
        r.move   = move_tbl[first];
        if (best) begin
            pick = first;
            for (int i = first + 1; i <= last; i++)
                if (weight_tbl[i] > weight_tbl[pick])
                    pick = i;
            r.move = move_tbl[pick];
            return r;
        end
        total = '0;
        for (int i = first; i <= last; i++)
            total += weight_tbl[i];
        if (total == 0)
            return r;
        rem = draw % total;
        for (int i = first; i <= last; i++) begin
            if (rem < weight_tbl[i]) begin
                r.move = move_tbl[i];
                return r;
            end
            rem -= weight_tbl[i];
        end
        return r;
    endfunction

    function void note_word(logic [skwp_pkg::ModeW-1:0] mode, logic [skwp_pkg::KeyW-1:0] key,
                            logic [skwp_pkg::MoveW-1:0] mv, logic [skwp_pkg::WeightW-1:0] wt,
                            bit best, logic [skwp_pkg::RandW-1:0] draw);
        t_reply r;
        r.status = skwp_pkg::StatDone;
        r.move   = '0;
        case (mode)
            skwp_pkg::ModeAppend: begin
                if (fill_count < skwp_pkg::TableDepthDefault) begin
                    key_tbl[fill_count]    = key;
                    move_tbl[fill_count]   = mv;
                    weight_tbl[fill_count] = wt;
                    fill_count++;
                end else begin
                    r.status = skwp_pkg::StatFull;
                end
            end
            skwp_pkg::ModeProbe: r = probe_reply(key, best, draw);
            skwp_pkg::ModeClear: fill_count = 0;
            default: ;
        endcase
        reply_q = {reply_q, r};
    endfunction

    function void check_reply(logic [skwp_pkg::StatusW-1:0] status,
                              logic [skwp_pkg::MoveW-1:0] mv);
        t_reply want;
        if (reply_q.size() == 0) begin
            flag($sformatf("unexpected result word status=%0d move=%h", status, mv));
            return;
        end
        want = reply_q.pop_front();
        if (status !== want.status)
            flag($sformatf("status expected %0d got %0d", want.status, status));
        if (mv !== want.move)
            flag($sformatf("move expected %h got %h", want.move, mv));
    endfunction
endclass

module tb_sorted_key_table_weighted_pick;
    import skwp_pkg::*;

    localparam int          Depth       = TableDepthDefault;
    localparam int unsigned RandomWords = 1100;
    localparam int unsigned CycleLimit  = 2_000_000;
    localparam int unsigned DrainCycles = 200;
    // the block ignores this mode and answers done
    localparam logic [ModeW-1:0] ModeSpare = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [ModeW-1:0]   i_mode;
    logic [KeyW-1:0]    i_key;
    logic [MoveW-1:0]   i_entry_move;
    logic [WeightW-1:0] i_entry_weight;
    logic               i_pick_best;
    logic [RandW-1:0]   i_random_value;
    logic               o_valid;
    logic [StatusW-1:0] o_status;
    logic [MoveW-1:0]   o_move;

    pick_scoreboard board;
    int unsigned    cycle_count = 0;
    int unsigned    word_count  = 0;   // words sent that the block does not ignore
    int unsigned    idle_pct    = 0;   // chance of a start gap before each word
    bit             calm        = 1'b0;
    logic [KeyW-1:0] key_list[$];      // keys in the table, in table order

    sorted_key_table_weighted_pick #(
        .TABLE_DEPTH(Depth)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_key          (i_key),
        .i_entry_move   (i_entry_move),
        .i_entry_weight (i_entry_weight),
        .i_pick_best    (i_pick_best),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_move         (o_move)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("sorted_key_table_weighted_pick test failed");
            $finish;
        end
    end

    // both sides sampled on the edge: result word checked first, since it always
    // belongs to an earlier word than the one taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                board.check_reply(o_status, o_move);
            if (start && !busy)
                board.note_word(i_mode, i_key, i_entry_move, i_entry_weight,
                                i_pick_best, i_random_value);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly small weights so weighted picks spread over the run, plus zeros and extremes
    function automatic logic [WeightW-1:0] pick_weight();
        case ($urandom_range(9))
            0, 1:          return '0;
            2, 3, 4, 5, 6: return WeightW'($urandom_range(1, 20));
            7, 8:          return WeightW'($urandom);
            default:       return '1;
        endcase
    endfunction

    function automatic logic [RandW-1:0] pick_draw();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // next ascending key: repeats build runs, the sum saturates at the top key
    function automatic logic [KeyW-1:0] next_key(logic [KeyW-1:0] k);
        logic [KeyW:0] sum;
        case ($urandom_range(9))
            0, 1, 2, 3: sum = {1'b0, k};
            4, 5, 6:    sum = {1'b0, k} + 65'($urandom_range(1, 4));
            7, 8:       sum = {1'b0, k} + 65'(rand64() >> $urandom_range(8, 40));
            default:    sum = {1'b0, k} + 65'(rand64() >> 1);
        endcase
        return sum[KeyW] ? '1 : sum[KeyW-1:0];
    endfunction

    // mostly keys present in the table, else their neighbors or noise
    function automatic logic [KeyW-1:0] probe_target();
        logic [KeyW-1:0] k;
        if (key_list.size() == 0)
            return rand64();
        k = key_list[$urandom_range(key_list.size() - 1)];
        case ($urandom_range(7))
            0:       return rand64();
            1:       return k + 1;
            2:       return k - 1;
            default: return k;
        endcase
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                             input logic [MoveW-1:0] mv, input logic [WeightW-1:0] wt,
                             input bit best, input logic [RandW-1:0] draw);
        int unsigned gap;
        // the last stretch runs without start gaps
        calm = word_count > RandomWords * 9 / 10;
        if (!calm && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= mode;
        i_key          <= key;
        i_entry_move   <= mv;
        i_entry_weight <= wt;
        i_pick_best    <= best;
        i_random_value <= draw;
        do @(posedge i_clk); while (busy);
        if (mode != ModeSpare)
            word_count++;
    endtask

    // unused fields carry noise on every mode
    task automatic append_entry(input logic [KeyW-1:0] key, input logic [MoveW-1:0] mv,
                                input logic [WeightW-1:0] wt);
        send_word(ModeAppend, key, mv, wt, 1'($urandom), $urandom);
        if (key_list.size() < Depth)
            key_list = {key_list, key};
    endtask

    task automatic probe_key(input logic [KeyW-1:0] key, input bit best,
                             input logic [RandW-1:0] draw);
        send_word(ModeProbe, key, MoveW'($urandom), WeightW'($urandom), best, draw);
    endtask

    task automatic clear_table();
        send_word(ModeClear, rand64(), MoveW'($urandom), WeightW'($urandom),
                  1'($urandom), $urandom);
        key_list.delete();
    endtask

    task automatic send_spare();
        send_word(ModeSpare, rand64(), MoveW'($urandom), WeightW'($urandom),
                  1'($urandom), $urandom);
    endtask

    // one load-then-probe phase with a sprinkle of noise
    task automatic run_sequence(input int unsigned loads, input int unsigned probes);
        logic [KeyW-1:0] k;
        if (key_list.size() == 0 || $urandom_range(3) != 0)
            clear_table();
        if (key_list.size() != 0)
            k = key_list[$];
        else if ($urandom_range(7) == 0)
            k = '0;
        else
            k = rand64() >> $urandom_range(0, 16);
        for (int n = 0; n < int'(loads); n++) begin
            append_entry(k, MoveW'($urandom), pick_weight());
            k = next_key(k);
            // an entry out of key order now and then
            if ($urandom_range(49) == 0)
                append_entry(rand64(), MoveW'($urandom), pick_weight());
            if ($urandom_range(29) == 0)
                send_spare();
        end
        for (int n = 0; n < int'(probes); n++) begin
            probe_key(probe_target(), 1'($urandom), pick_draw());
            if ($urandom_range(39) == 0)
                send_spare();
        end
    endtask

    // whole table in one go to reach the full case
    task automatic fill_whole_table();
        logic [KeyW-1:0] k;
        clear_table();
        k = KeyW'($urandom_range(0, 3));
        while (key_list.size() < Depth) begin
            append_entry(k, MoveW'($urandom), pick_weight());
            if ($urandom_range(2) != 0)
                k = k + KeyW'($urandom_range(1, 1 << 20));
        end
        // a full table refuses more entries and keeps its content
        repeat (3) append_entry(k + 1, MoveW'($urandom), pick_weight());
        repeat (40) probe_key(probe_target(), 1'($urandom), pick_draw());
    endtask

    initial begin
        int unsigned phase;
        board = new();
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_mode         <= ModeAppend;
        i_key          <= '0;
        i_entry_move   <= '0;
        i_entry_weight <= '0;
        i_pick_best    <= 1'b0;
        i_random_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, the ignored mode, field extremes
        probe_key(64'd5, 1'b1, 32'd0);
        send_spare();
        append_entry('0, '1, '0);
        append_entry('0, 16'h0001, '0);
        append_entry(64'd5, 16'h1234, '1);
        append_entry(64'd5, 16'h0002, '1);
        append_entry(64'd5, 16'h0003, 16'h0001);
        append_entry('1, 16'hAAAA, 16'h5555);
        // weight tie in best mode goes to the first entry of the run
        probe_key('0, 1'b1, '1);
        // zero total weight gives the first move
        probe_key('0, 1'b0, '1);
        probe_key(64'd5, 1'b1, '0);
        probe_key(64'd5, 1'b0, '1);
        probe_key(64'd5, 1'b0, 32'd65535);
        probe_key(64'd5, 1'b0, 32'd131070);
        probe_key('1, 1'b1, '0);
        probe_key('1, 1'b0, 32'h8000_0000);
        probe_key(64'd3, 1'b1, '0);
        probe_key(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '1);
        // a key below the last one breaks the order
        append_entry(64'd1, 16'h0007, 16'h0007);
        probe_key(64'd1, 1'b1, '0);
        probe_key(64'd5, 1'b0, 32'd3);
        clear_table();
        probe_key(64'd5, 1'b1, '0);
        append_entry(64'h8000_0000_0000_0000, 16'h5A5A, 16'hA5A5);
        probe_key(64'h8000_0000_0000_0000, 1'b0, '1);

        // random phases; the full table load comes early and counts toward the total
        word_count = 0;
        phase      = 0;
        while (word_count < RandomWords) begin
            case ($urandom_range(2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 50;
            endcase
            if (phase == 1)
                fill_whole_table();
            else
                run_sequence($urandom_range(0, 40), $urandom_range(1, 24));
            phase++;
        end
        start <= 1'b0;

        while (board.reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (board.reply_q.size() != 0)
            board.flag($sformatf("%0d result words never arrived", board.reply_q.size()));
        if (board.mismatch_count == 0)
            $display("sorted_key_table_weighted_pick test passed");
        else
            $display("sorted_key_table_weighted_pick test failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/skwp_pkg.sv
hw/rtl/skwp_mod.sv
hw/rtl/sorted_key_table_weighted_pick.sv
verif/tb_sorted_key_table_weighted_pick.sv
